// File: rtl/keyword_table_cipher_core_defines.svh
// ----------------------------------------------------------------------------
// Keyword table cipher: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_TABLE_CIPHER_CORE_DEFINES_SVH
`define KEYWORD_TABLE_CIPHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define KTC_ASSERT_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define KTC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define KTC_ASSERT_IMPLY(lbl, pre, post, msg)
`define KTC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: rtl/ktc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword table cipher: package
// Widths, command codes, controller states and alphabet constants.
// ----------------------------------------------------------------------------
package ktc_pkg;

	localparam int ROWS_DEF = 6;
	localparam int COLS_DEF = 6;
	localparam int SYM_W    = 8;
	localparam int CMD_W    = 2;
	localparam int LETTERS  = 26;
	localparam int LETTER_W = 5;
	localparam int REV_DEPTH = 2 ** SYM_W;

	localparam logic [SYM_W-1:0] CHAR_A = 8'h41;
	localparam logic [SYM_W-1:0] CHAR_Z = 8'h5A;

	typedef enum logic [CMD_W-1:0] {
		CMD_KEY    = 2'd0,
		CMD_FINISH = 2'd1,
		CMD_ENCODE = 2'd2,
		CMD_DECODE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KEY,
		ST_FILL,
		ST_LOOK,
		ST_RES
	} state_t;

endpackage

// File: rtl/ktc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword table cipher: channel interfaces
// Request channel (command, symbol) and response channel (out_symbol, found).
// ----------------------------------------------------------------------------
interface ktc_req_if;
	logic                         valid;
	logic                         ready;
	logic [ktc_pkg::CMD_W-1:0]    command;
	logic [ktc_pkg::SYM_W-1:0]    symbol;

	modport source (output valid, output command, output symbol, input ready);
	modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface ktc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ktc_pkg::SYM_W-1:0]    out_symbol;
	logic                         found;

	modport source (output valid, output out_symbol, output found, input ready);
	modport sink   (input valid, input out_symbol, input found, output ready);
endinterface

// File: rtl/keyword_table_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword table cipher core
// ROWS x COLS keyword table with a reverse symbol map; encodes and decodes
// bytes by moving one row down or up in the matching column.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command per transaction: key letter, finish, encode or
//   decode, with its symbol. rsp returns exactly one transaction for each.
//   Key letter: reverse map read, then cell and map write.
//   Finish: scans the letters from A, used or not, and writes each unused
//   one to the next free cell until the table is full or Z is passed (at
//   once if the table is already closed), then gives the result.
//   Encode/decode: reverse map read, then a cell read, then the result; a
//   following request of any kind is taken as the result is loaded, so
//   the next encode/decode starts only after the two synchronous memory
//   reads of the last one, which run in series, are done.
//   After reset the reverse map (one entry per byte value) is swept clear;
//   req.ready stays low during the sweep.
//   rsp is a registered output; while it is stalled the core carries the
//   current transaction up to its result (a key's table write waits with
//   it) and holds with req.ready low until the result register frees up.
// ----------------------------------------------------------------------------
`include "keyword_table_cipher_core_defines.svh"

module keyword_table_cipher_core #(
	parameter int ROWS = ktc_pkg::ROWS_DEF,
	parameter int COLS = ktc_pkg::COLS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ktc_req_if.sink   req,
	ktc_rsp_if.source rsp
);

	localparam int RW = $clog2(ROWS);
	localparam int FW = $clog2(ROWS + 1);
	localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int SW = ktc_pkg::SYM_W;
	localparam int LW = ktc_pkg::LETTER_W;

	typedef struct packed {
		logic          valid;
		logic [RW-1:0] row;
		logic [CW-1:0] col;
	} rev_entry_t;

	ktc_pkg::state_t state_q, state_d;

	rev_entry_t        rev_mem [ktc_pkg::REV_DEPTH];
	rev_entry_t        rev_rd_q;
	logic [SW-1:0]     cell_mem [ROWS][COLS];
	logic [SW-1:0]     cell_rd_q;

	logic [SW-1:0]     clr_q;
	logic [FW-1:0]     fill_row_q;
	logic [CW-1:0]     fill_col_q;
	logic              closed_q;
	logic [ktc_pkg::LETTERS-1:0] letter_used_q;
	logic [LW-1:0]     letter_q;

	logic [SW-1:0]     sym_q;
	ktc_pkg::cmd_t     cmd_q;
	logic              hit_s2;
	logic              tgt_ok_s2;

	logic              out_valid_q;
	logic [SW-1:0]     out_sym_q;
	logic              out_found_q;

	logic              req_ready;
	logic              req_fire;
	logic              out_free;
	logic              table_full;
	logic              fill_done;
	logic              key_store;
	logic              rev_we;
	logic [SW-1:0]     rev_waddr;
	rev_entry_t        rev_wdata;
	logic              cell_we;
	logic [SW-1:0]     cell_wdata;
	logic              fill_adv;
	logic              letter_adv;
	logic              closed_set;
	logic              mark_letter;
	logic              out_load;
	logic [SW-1:0]     out_sym_d;
	logic              out_found_d;
	logic [RW-1:0]     tgt_row;
	logic              tgt_ok;
	logic [SW-1:0]     sym_off;
	logic [SW-1:0]     fill_sym;
	ktc_pkg::state_t   accept_state;

	assign req_fire   = req.valid && req_ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign table_full = (fill_row_q == FW'(ROWS));
	assign fill_done  = closed_q || table_full || (letter_q == LW'(ktc_pkg::LETTERS));
	assign key_store  = !closed_q && !table_full;
	assign sym_off    = sym_q - ktc_pkg::CHAR_A;
	assign fill_sym   = ktc_pkg::CHAR_A + SW'(letter_q);

	// neighbour row for encode (down) or decode (up), with wrap
	always_comb begin
		if (cmd_q == ktc_pkg::CMD_ENCODE) begin
			tgt_row = (rev_rd_q.row == RW'(ROWS - 1)) ? '0 : rev_rd_q.row + RW'(1);
		end else begin
			tgt_row = (rev_rd_q.row == '0) ? RW'(ROWS - 1) : rev_rd_q.row - RW'(1);
		end
		tgt_ok = (FW'(tgt_row) < fill_row_q) ||
			((FW'(tgt_row) == fill_row_q) && (rev_rd_q.col < fill_col_q));
	end

	always_comb begin
		case (ktc_pkg::cmd_t'(req.command))
			ktc_pkg::CMD_KEY:    accept_state = ktc_pkg::ST_KEY;
			ktc_pkg::CMD_FINISH: accept_state = ktc_pkg::ST_FILL;
			default:             accept_state = ktc_pkg::ST_LOOK;
		endcase
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		rev_we      = 1'b0;
		rev_waddr   = sym_q;
		rev_wdata   = '0;
		cell_we     = 1'b0;
		cell_wdata  = sym_q;
		fill_adv    = 1'b0;
		letter_adv  = 1'b0;
		closed_set  = 1'b0;
		mark_letter = 1'b0;
		out_load    = 1'b0;
		out_sym_d   = sym_q;
		out_found_d = 1'b0;
		case (state_q)
			ktc_pkg::ST_CLEAR: begin
				rev_we    = 1'b1;
				rev_waddr = clr_q;
				if (clr_q == '1) begin
					state_d = ktc_pkg::ST_IDLE;
				end
			end
			ktc_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req.valid) begin
					state_d = accept_state;
				end
			end
			ktc_pkg::ST_KEY: begin
				if (out_free) begin
					out_load    = 1'b1;
					out_found_d = key_store;
					if (key_store) begin
						cell_we     = 1'b1;
						rev_we      = !rev_rd_q.valid;
						rev_wdata   = '{valid: 1'b1, row: fill_row_q[RW-1:0], col: fill_col_q};
						fill_adv    = 1'b1;
						mark_letter = sym_q inside {[ktc_pkg::CHAR_A:ktc_pkg::CHAR_Z]};
					end
					state_d = ktc_pkg::ST_IDLE;
				end
			end
			ktc_pkg::ST_FILL: begin
				if (fill_done) begin
					if (out_free) begin
						out_load   = 1'b1;
						out_sym_d  = '0;
						closed_set = 1'b1;
						state_d    = ktc_pkg::ST_IDLE;
					end
				end else begin
					letter_adv = 1'b1;
					if (!letter_used_q[letter_q]) begin
						cell_we    = 1'b1;
						cell_wdata = fill_sym;
						rev_we     = 1'b1;
						rev_waddr  = fill_sym;
						rev_wdata  = '{valid: 1'b1, row: fill_row_q[RW-1:0], col: fill_col_q};
						fill_adv   = 1'b1;
					end
				end
			end
			ktc_pkg::ST_LOOK: begin
				state_d = ktc_pkg::ST_RES;
			end
			ktc_pkg::ST_RES: begin
				if (out_free) begin
					out_load    = 1'b1;
					out_sym_d   = (hit_s2 && tgt_ok_s2) ? cell_rd_q : sym_q;
					out_found_d = hit_s2;
					req_ready   = 1'b1;
					state_d     = req.valid ? accept_state : ktc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ktc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ktc_pkg::ST_CLEAR;
			clr_q         <= '0;
			fill_row_q    <= '0;
			fill_col_q    <= '0;
			closed_q      <= 1'b0;
			letter_used_q <= '0;
			letter_q      <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ktc_pkg::ST_CLEAR) begin
				clr_q <= clr_q + SW'(1);
			end
			if (fill_adv) begin
				if (fill_col_q == CW'(COLS - 1)) begin
					fill_col_q <= '0;
					fill_row_q <= fill_row_q + FW'(1);
				end else begin
					fill_col_q <= fill_col_q + CW'(1);
				end
			end
			if (closed_set) begin
				closed_q <= 1'b1;
			end
			if (mark_letter) begin
				letter_used_q[sym_off[LW-1:0]] <= 1'b1;
			end
			if (req_fire) begin
				letter_q <= '0;
			end else if (letter_adv) begin
				letter_q <= letter_q + LW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// transaction payload and pipeline data
	always_ff @(posedge clk) begin
		if (req_fire) begin
			sym_q <= req.symbol;
			cmd_q <= ktc_pkg::cmd_t'(req.command);
		end
		if (state_q == ktc_pkg::ST_LOOK) begin
			hit_s2    <= rev_rd_q.valid;
			tgt_ok_s2 <= tgt_ok;
		end
		if (out_load) begin
			out_sym_q   <= out_sym_d;
			out_found_q <= out_found_d;
		end
	end

	// reverse map: byte value -> first cell holding it
	always_ff @(posedge clk) begin
		if (rev_we) begin
			rev_mem[rev_waddr] <= rev_wdata;
		end
		if (req_fire) begin
			rev_rd_q <= rev_mem[req.symbol];
		end
	end

	// cell table
	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_mem[fill_row_q[RW-1:0]][fill_col_q] <= cell_wdata;
		end
		if (state_q == ktc_pkg::ST_LOOK) begin
			cell_rd_q <= cell_mem[tgt_row][rev_rd_q.col];
		end
	end

	assign req.ready      = req_ready;
	assign rsp.valid      = out_valid_q;
	assign rsp.out_symbol = out_sym_q;
	assign rsp.found      = out_found_q;

	`KTC_ASSERT_IMPLY(a_fill_bound, 1'b1,
		(fill_row_q < FW'(ROWS)) || (table_full && (fill_col_q == '0)),
		"fill position beyond table")
	`KTC_ASSERT_NEXT(a_closed_sticks, closed_q, closed_q, "table reopened without reset")
	`KTC_ASSERT_NEXT(a_key_interlock,
		req_fire && (ktc_pkg::cmd_t'(req.command) == ktc_pkg::CMD_KEY),
		!req.ready, "request taken while key write pending")
	`KTC_ASSERT_NEXT(a_fill_step, (state_q == ktc_pkg::ST_FILL) && !fill_done,
		letter_q == $past(letter_q) + LW'(1), "finish sweep skipped a letter")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyword table cipher core: testbench
// Drives key, finish, encode and decode commands through the request
// channel, mirrors the table in a behavioural predictor and checks every
// response transaction in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CELLS      = ktc_pkg::ROWS_DEF * ktc_pkg::COLS_DEF;
	localparam int IDLE_LIMIT = 3000;
	localparam int TAIL       = 40;
	localparam int RANDOM_N   = 2000;

	typedef struct {
		ktc_pkg::cmd_t             command;
		logic [ktc_pkg::SYM_W-1:0] symbol;
		bit                        drain;
	} request_t;

	typedef struct {
		logic [ktc_pkg::SYM_W-1:0] out_symbol;
		logic                      found;
	} cipher_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ktc_req_if req();
	ktc_rsp_if rsp();

	keyword_table_cipher_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	request_t       pending_requests[$];
	cipher_result_t cipher_expected[$];

	logic [ktc_pkg::SYM_W-1:0] table_symbol [CELLS];
	bit                        table_filled [CELLS];
	bit                        letter_taken [ktc_pkg::LETTERS];
	int                        filled_cells;

	int fail_count;
	int send_gap;
	int recv_gap;
	int idle_cycles;
	int cycle_count;
	bit no_idle;

	function automatic int draw_gap();
		if (no_idle)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	task automatic cipher_step(input ktc_pkg::cmd_t command,
			input logic [ktc_pkg::SYM_W-1:0] symbol);
		cipher_result_t r;
		int hit_cell;
		int row;
		int col;
		int target;
		int letter;
		r.out_symbol = symbol;
		r.found = 1'b0;
		hit_cell = -1;
		case (command)
		ktc_pkg::CMD_KEY: begin
			if (filled_cells < CELLS) begin
				table_symbol[filled_cells] = symbol;
				table_filled[filled_cells] = 1'b1;
				if (symbol >= ktc_pkg::CHAR_A && symbol <= ktc_pkg::CHAR_Z)
					letter_taken[symbol - ktc_pkg::CHAR_A] = 1'b1;
				filled_cells++;
				r.found = 1'b1;
			end
		end
		ktc_pkg::CMD_FINISH: begin
			letter = 0;
			while (filled_cells < CELLS) begin
				while (letter < ktc_pkg::LETTERS && letter_taken[letter])
					letter++;
				if (letter >= ktc_pkg::LETTERS)
					break;
				table_symbol[filled_cells] = ktc_pkg::CHAR_A + letter[ktc_pkg::SYM_W-1:0];
				table_filled[filled_cells] = 1'b1;
				letter++;
				filled_cells++;
			end
			filled_cells = CELLS;
			r.out_symbol = '0;
		end
		default: begin
			for (int k = CELLS - 1; k >= 0; k--)
				if (table_filled[k] && table_symbol[k] == symbol)
					hit_cell = k;
			if (hit_cell >= 0) begin
				row = hit_cell / ktc_pkg::COLS_DEF;
				col = hit_cell % ktc_pkg::COLS_DEF;
				if (command == ktc_pkg::CMD_ENCODE)
					row = (row == ktc_pkg::ROWS_DEF - 1) ? 0 : row + 1;
				else
					row = (row == 0) ? ktc_pkg::ROWS_DEF - 1 : row - 1;
				target = row * ktc_pkg::COLS_DEF + col;
				if (table_filled[target])
					r.out_symbol = table_symbol[target];
				r.found = 1'b1;
			end
		end
		endcase
		cipher_expected.push_back(r);
	endtask

	task automatic add_request(input ktc_pkg::cmd_t command,
			input logic [ktc_pkg::SYM_W-1:0] symbol, input bit drain);
		request_t item;
		item.command = command;
		item.symbol = symbol;
		item.drain = drain;
		pending_requests.push_back(item);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.command <= ktc_pkg::CMD_KEY;
			req.symbol <= '0;
			send_gap = 0;
		end else begin
			if (req.valid && req.ready) begin
				cipher_step(ktc_pkg::cmd_t'(req.command), req.symbol);
				send_gap = draw_gap();
			end
			if (!req.valid || req.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (pending_requests.size() != 0 &&
						!(pending_requests[0].drain && cipher_expected.size() != 0)) begin
					req.valid <= 1'b1;
					req.command <= pending_requests[0].command;
					req.symbol <= pending_requests[0].symbol;
					pending_requests.pop_front();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (cipher_expected.size() == 0) begin
					$display("%0t: unexpected transaction: expected none, actual %02h/%0b",
						$time, rsp.out_symbol, rsp.found);
					fail_count++;
				end else begin
					if (rsp.out_symbol !== cipher_expected[0].out_symbol) begin
						$display("%0t: out_symbol mismatch: expected %02h, actual %02h",
							$time, cipher_expected[0].out_symbol, rsp.out_symbol);
						fail_count++;
					end
					if (rsp.found !== cipher_expected[0].found) begin
						$display("%0t: found mismatch: expected %0b, actual %0b",
							$time, cipher_expected[0].found, rsp.found);
						fail_count++;
					end
					cipher_expected.pop_front();
				end
				recv_gap = draw_gap();
			end
			if (recv_gap > 0) begin
				recv_gap--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog; also switch idling off for some stretches
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 400 == 0)
			no_idle <= ($urandom_range(0, 2) == 0);
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int pick;
		logic [ktc_pkg::SYM_W-1:0] sym;
		ktc_pkg::cmd_t command;
		fail_count = 0;
		idle_cycles = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		filled_cells = 0;
		for (int k = 0; k < CELLS; k++) begin
			table_symbol[k] = '0;
			table_filled[k] = 1'b0;
		end
		for (int k = 0; k < ktc_pkg::LETTERS; k++)
			letter_taken[k] = 1'b0;

		add_request(ktc_pkg::CMD_ENCODE, ktc_pkg::CHAR_A, 1'b0);
		add_request(ktc_pkg::CMD_DECODE, 8'h00, 1'b0);
		add_request(ktc_pkg::CMD_KEY, "K", 1'b0);
		add_request(ktc_pkg::CMD_KEY, "E", 1'b0);
		add_request(ktc_pkg::CMD_KEY, "Y", 1'b0);
		add_request(ktc_pkg::CMD_KEY, "K", 1'b0);
		add_request(ktc_pkg::CMD_KEY, 8'h00, 1'b0);
		add_request(ktc_pkg::CMD_KEY, 8'hFF, 1'b0);
		add_request(ktc_pkg::CMD_KEY, "a", 1'b0);
		add_request(ktc_pkg::CMD_ENCODE, "K", 1'b0);
		add_request(ktc_pkg::CMD_DECODE, "Y", 1'b0);
		add_request(ktc_pkg::CMD_FINISH, 8'h00, 1'b0);
		add_request(ktc_pkg::CMD_FINISH, 8'hFF, 1'b0);
		add_request(ktc_pkg::CMD_KEY, "Q", 1'b0);
		add_request(ktc_pkg::CMD_ENCODE, "K", 1'b0);
		add_request(ktc_pkg::CMD_DECODE, "K", 1'b0);
		add_request(ktc_pkg::CMD_ENCODE, ktc_pkg::CHAR_Z, 1'b0);
		add_request(ktc_pkg::CMD_DECODE, ktc_pkg::CHAR_A, 1'b0);
		add_request(ktc_pkg::CMD_ENCODE, 8'hFF, 1'b0);
		add_request(ktc_pkg::CMD_DECODE, 8'h00, 1'b0);
		add_request(ktc_pkg::CMD_ENCODE, 8'h80, 1'b0);
		add_request(ktc_pkg::CMD_DECODE, "Q", 1'b0);
		add_request(ktc_pkg::CMD_ENCODE, "a", 1'b0);

		for (int n = 0; n < RANDOM_N; n++) begin
			pick = $urandom_range(0, 99);
			command = ($urandom_range(0, 1) == 0) ? ktc_pkg::CMD_ENCODE : ktc_pkg::CMD_DECODE;
			if (pick < 60) begin
				sym = ktc_pkg::CHAR_A + 8'($urandom_range(0, ktc_pkg::LETTERS - 1));
			end else if (pick < 70) begin
				case ($urandom_range(0, 2))
				0: sym = 8'h00;
				1: sym = 8'hFF;
				default: sym = "a";
				endcase
			end else begin
				sym = 8'($urandom_range(0, 255));
				if (pick >= 95)
					command = ($urandom_range(0, 1) == 0) ? ktc_pkg::CMD_KEY :
						ktc_pkg::CMD_FINISH;
			end
			add_request(command, sym, (n == 0) || ($urandom_range(0, 99) == 0));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_requests.size() != 0 || req.valid || cipher_expected.size() != 0);
		repeat (TAIL) @(posedge clk);

		if (cipher_expected.size() != 0) begin
			$display("%0t: %0d expected transactions never arrived",
				$time, cipher_expected.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
